FILE: sv/bdq_pkg.sv
// Shared types and defaults for the bounded deque with remove-by-value.
package bdq_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ACT_APPEND   = 3'd0,
    ACT_RM_FRONT = 3'd1,
    ACT_RM_BACK  = 3'd2,
    ACT_RM_VALUE = 3'd3,
    ACT_PEEK     = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

endpackage

FILE: sv/bdq_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the deque slots.
module bdq_ram #(
  parameter int unsigned DEPTH = bdq_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bounded_deque_with_remove.sv
// Top level of the bounded deque: request sequencer, slot RAM and result register.
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+-------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tuser: action; tdata: value
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tuser: status; tdata: data_out, count_out
//
//  One request at a time. Append, clear, ignored actions and any remove or peek on an
//  empty store go from EXEC straight to DONE; remove front/back and peek otherwise
//  pass through READ for one RAM read. Remove value reads one entry per cycle through
//  the single RAM read port, then on a hit moves each later entry down one slot per cycle.
//  Reset clears state, front, count and m_axis valid; slot contents are left as they are.
//  A new request is taken while a finished result still waits on m_axis.
module bounded_deque_with_remove #(
  parameter int unsigned CAPACITY   = bdq_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] data_out, [36:32] count_out, [39:37] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned OW    = CNT_W + 1;

  bdq_pkg::state_e  state_q, state_d;
  logic [2:0]            act_q, act_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [IDX_W-1:0]      front_q, front_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  bdq_pkg::status_e      res_status_q, res_status_d;
  logic [DATA_WIDTH-1:0] res_data_q, res_data_d;

  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                  s_accept, out_free;
  logic                  full, empty, match, more, shift_more;
  logic [OW-1:0]         cnt_x, pos0, pos1, pos2, cnt_m1;
  logic [63:0]           val_wide, data_wide, cnt_wide;
  logic                  m_valid_q;
  logic [31:0]           m_data_q;
  logic [4:0]            m_count_q;
  logic [1:0]            m_status_q;

  // Physical slot of logical position k; k + front stays below twice the capacity.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                input logic [OW-1:0] k);
    logic [OW:0] p;
    p = (OW+1)'(front) + (OW+1)'(k);
    if (p >= (OW+1)'(CAPACITY)) begin
      p = p - (OW+1)'(CAPACITY);
    end
    return p[IDX_W-1:0];
  endfunction

  bdq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign s_axis_tready = (state_q == bdq_pkg::S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign val_wide = 64'(s_axis_tdata);
  assign cnt_x    = OW'(count_q);
  assign pos0     = OW'(pos_q);
  assign pos1     = pos0 + OW'(1);
  assign pos2     = pos0 + OW'(2);
  assign cnt_m1   = cnt_x - OW'(1);

  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign match      = (mem_rdata == val_q);
  assign more       = (pos1 < cnt_x);
  assign shift_more = (pos2 < cnt_x);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (s_accept) state_d = bdq_pkg::S_EXEC;
      end
      bdq_pkg::S_EXEC: begin
        state_d = bdq_pkg::S_DONE;
        case (act_q)
          bdq_pkg::ACT_RM_FRONT, bdq_pkg::ACT_RM_BACK, bdq_pkg::ACT_PEEK: begin
            if (!empty) state_d = bdq_pkg::S_READ;
          end
          bdq_pkg::ACT_RM_VALUE: begin
            if (!empty) state_d = bdq_pkg::S_SCAN;
          end
          default: state_d = bdq_pkg::S_DONE;
        endcase
      end
      bdq_pkg::S_READ: state_d = bdq_pkg::S_DONE;
      bdq_pkg::S_SCAN: begin
        if (match && more) begin
          state_d = bdq_pkg::S_SHIFT;
        end else if (!match && more) begin
          state_d = bdq_pkg::S_SCAN;
        end else begin
          state_d = bdq_pkg::S_DONE;
        end
      end
      bdq_pkg::S_SHIFT: begin
        if (!shift_more) state_d = bdq_pkg::S_DONE;
      end
      bdq_pkg::S_DONE: begin
        if (out_free) state_d = bdq_pkg::S_IDLE;
      end
      default: state_d = bdq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    act_d        = act_q;
    val_d        = val_q;
    front_d      = front_q;
    count_d      = count_q;
    pos_d        = pos_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = slot_of(front_q, cnt_x);
    mem_raddr    = front_q;
    mem_wdata    = val_q;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (s_accept) begin
          act_d = s_axis_tuser;
          val_d = val_wide[DATA_WIDTH-1:0];
          pos_d = '0;
        end
      end
      bdq_pkg::S_EXEC: begin
        res_status_d = bdq_pkg::ST_OK;
        res_data_d   = '0;
        case (act_q)
          bdq_pkg::ACT_APPEND: begin
            if (full) begin
              res_status_d = bdq_pkg::ST_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
          bdq_pkg::ACT_RM_FRONT, bdq_pkg::ACT_RM_BACK, bdq_pkg::ACT_PEEK,
          bdq_pkg::ACT_RM_VALUE: begin
            if (empty) begin
              res_status_d = bdq_pkg::ST_EMPTY;
            end else begin
              mem_re = 1'b1;
              if (act_q inside {bdq_pkg::ACT_RM_BACK, bdq_pkg::ACT_PEEK}) begin
                mem_raddr = slot_of(front_q, cnt_m1);
              end
            end
          end
          bdq_pkg::ACT_CLEAR: begin
            count_d = '0;
            front_d = '0;
          end
          default: res_status_d = bdq_pkg::ST_OK;
        endcase
      end
      bdq_pkg::S_READ: begin
        res_data_d = mem_rdata;
        if (act_q == bdq_pkg::ACT_RM_FRONT) begin
          front_d = slot_of(front_q, OW'(1));
          count_d = count_q - CNT_W'(1);
        end else if (act_q == bdq_pkg::ACT_RM_BACK) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      bdq_pkg::S_SCAN: begin
        // fetch the next entry while comparing this one
        mem_re    = 1'b1;
        mem_raddr = slot_of(front_q, pos1);
        if (match) begin
          res_data_d = val_q;
          if (!more) count_d = count_q - CNT_W'(1);
        end else if (more) begin
          pos_d = pos1[IDX_W-1:0];
        end else begin
          res_status_d = bdq_pkg::ST_EMPTY;
        end
      end
      bdq_pkg::S_SHIFT: begin
        // slot j takes j+1; the read of j+2 never hits the slot being written
        mem_we    = 1'b1;
        mem_waddr = slot_of(front_q, pos0);
        mem_wdata = mem_rdata;
        if (shift_more) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(front_q, pos2);
          pos_d     = pos1[IDX_W-1:0];
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: pos_d = pos_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::S_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    val_q        <= val_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
  end

  assign data_wide = 64'(res_data_q);
  assign cnt_wide  = 64'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == bdq_pkg::S_DONE && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bdq_pkg::S_DONE && out_free) begin
      m_data_q   <= data_wide[31:0];
      m_count_q  <= cnt_wide[4:0];
      m_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_count_q, m_data_q};
  assign m_axis_tuser  = m_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OW'(count_q) <= OW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same slot in one cycle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == bdq_pkg::S_DONE))
    else $error("result issued outside the done state");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == bdq_pkg::S_EXEC && !s_axis_tready))
    else $error("request accepted while another is in progress");

endmodule
